### sv/scab_pkg.sv
// Shared widths, register indexes, sideband types and the divide-by-255 helper.
`timescale 1ns / 1ps

package scab_pkg;

	localparam int IMG_W      = 15;
	localparam int RECT_W     = 12;
	localparam int SCR_W      = 13;
	localparam int OFS_W      = 12;
	localparam int IDX_W      = 14;
	localparam int PIX_W      = 32;
	localparam int ADDR_W     = 26;
	localparam int COLOR_W    = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;
	localparam int NUM_W      = OFS_W + IMG_W;   // offset times image size
	localparam int SRC_W      = IMG_W;           // source column / row
	localparam int PROD_W     = 16;              // channel times alpha

	// source store depth; a power of two so the index wrap is a truncation
	localparam int SOURCE_DEPTH = 2 ** IDX_W;

	localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMG_HEIGHT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RECT_X        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RECT_Y        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RECT_WIDTH    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RECT_HEIGHT   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd7;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_DRAW = 1'b1;

	// carried alongside the scaling dividers
	typedef struct packed {
		logic             action;
		logic             ok;
		logic [SCR_W-1:0] px;
		logic [SCR_W-1:0] py;
		logic [IDX_W-1:0] load_index;
		logic [PIX_W-1:0] load_pixel;
	} xy_side_t;

	// carried to the store access
	typedef struct packed {
		logic              action;
		logic              ok;
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  pixel;
	} md_side_t;

	// floor(x / 255) for x <= 255*255: x = 256*q0 + lo leaves q0 + lo < 510
	function automatic logic [7:0] div255(input logic [PROD_W-1:0] x);
		logic [8:0] r;
		r = {1'b0, x[7:0]} + {1'b0, x[15:8]};
		return x[15:8] + {7'd0, (r >= 9'd255)};
	endfunction

endpackage

### sv/scab_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module scab_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

### sv/scab_div.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes in step.
`timescale 1ns / 1ps

module scab_div #(
	parameter int LANES = 1,
	parameter int NW    = 8,
	parameter int DW    = 8,
	parameter int QB    = 8,
	parameter int SW    = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [LANES-1:0][NW-1:0]     num,
	input  logic [LANES-1:0][DW-1:0]     den,
	input  logic [SW-1:0]                in_side,
	output logic                         out_valid,
	output logic [LANES-1:0][QB-1:0]     quo,
	output logic [LANES-1:0][DW-1:0]     rem,
	output logic [SW-1:0]                out_side
);

	localparam int CW = (NW > DW + QB) ? NW : DW + QB;

	logic [QB-1:0]                       v_s;
	logic [QB-1:0][LANES-1:0][CW-1:0]    rem_s;
	logic [QB-1:0][LANES-1:0][QB-1:0]    quo_s;
	logic [QB-1:0][LANES-1:0][DW-1:0]    den_s;
	logic [QB-1:0][SW-1:0]               side_s;

	logic [QB-1:0]                       v_nx;
	logic [QB-1:0][LANES-1:0][CW-1:0]    rem_nx;
	logic [QB-1:0][LANES-1:0][QB-1:0]    quo_nx;
	logic [QB-1:0][LANES-1:0][DW-1:0]    den_nx;
	logic [QB-1:0][SW-1:0]               side_nx;

	// stage i settles quotient bit QB-1-i
	always_comb begin
		logic [CW-1:0] r_in;
		logic [CW-1:0] shf;
		logic [QB-1:0] q_in;
		logic [DW-1:0] d_in;
		logic          ge;
		for (int i = 0; i < QB; i++) begin
			if (i == 0) begin
				v_nx[i]    = in_valid;
				side_nx[i] = in_side;
			end else begin
				v_nx[i]    = v_s[i-1];
				side_nx[i] = side_s[i-1];
			end
			for (int l = 0; l < LANES; l++) begin
				if (i == 0) begin
					r_in = CW'(num[l]);
					q_in = '0;
					d_in = den[l];
				end else begin
					r_in = rem_s[i-1][l];
					q_in = quo_s[i-1][l];
					d_in = den_s[i-1][l];
				end
				shf = CW'(d_in) << (QB - 1 - i);
				ge  = (r_in >= shf);
				rem_nx[i][l] = ge ? (r_in - shf) : r_in;
				quo_nx[i][l] = q_in;
				quo_nx[i][l][QB-1-i] = ge;
				den_nx[i][l] = d_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= v_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s  <= rem_nx;
			quo_s  <= quo_nx;
			den_s  <= den_nx;
			side_s <= side_nx;
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			quo[l] = quo_s[QB-1][l];
			rem[l] = rem_s[QB-1][l][DW-1:0];
		end
	end

	assign out_valid = v_s[QB-1];
	assign out_side  = side_s[QB-1];

endmodule

### sv/scaled_alpha_image_blit.sv
// Nearest-neighbor scaled alpha blit into a frame buffer, one item per clock.
// 21 register stages: products, 15 stages of column/row scaling divide,
// row times width, store index, RAM read, alpha and the output register.
// Throughput: one item per cycle; the whole pipeline holds while the result is not taken.
// Reset clears valid bits and loads register defaults; the source store is not cleared.
`timescale 1ns / 1ps

module scaled_alpha_image_blit #(
	parameter int BYTES_PER_PIXEL = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [scab_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [scab_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                action,
	input  logic [scab_pkg::IDX_W-1:0]          load_index,
	input  logic [scab_pkg::PIX_W-1:0]          load_pixel,
	input  logic [scab_pkg::OFS_W-1:0]          offset_x,
	input  logic [scab_pkg::OFS_W-1:0]          offset_y,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                write_enable,
	output logic [scab_pkg::ADDR_W-1:0]         write_address,
	output logic [scab_pkg::COLOR_W-1:0]        write_color
);

	import scab_pkg::*;

	// configuration
	logic [IMG_W-1:0]  img_width_q, img_height_q;
	logic [RECT_W-1:0] rect_x_q, rect_y_q, rect_width_q, rect_height_q;
	logic [SCR_W-1:0]  screen_width_q, screen_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_width_q     <= IMG_W'(128);
			img_height_q    <= IMG_W'(128);
			rect_x_q        <= '0;
			rect_y_q        <= '0;
			rect_width_q    <= RECT_W'(128);
			rect_height_q   <= RECT_W'(128);
			screen_width_q  <= SCR_W'(800);
			screen_height_q <= SCR_W'(480);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IMG_WIDTH:     img_width_q     <= cfg_data[IMG_W-1:0];
				CFG_IMG_HEIGHT:    img_height_q    <= cfg_data[IMG_W-1:0];
				CFG_RECT_X:        rect_x_q        <= cfg_data[RECT_W-1:0];
				CFG_RECT_Y:        rect_y_q        <= cfg_data[RECT_W-1:0];
				CFG_RECT_WIDTH:    rect_width_q    <= cfg_data[RECT_W-1:0];
				CFG_RECT_HEIGHT:   rect_height_q   <= cfg_data[RECT_W-1:0];
				CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data[SCR_W-1:0];
				CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data[SCR_W-1:0];
			endcase
		end
	end

	logic en;
	logic out_valid_q;
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// stage 1: scaling products, screen position, bounds and clip
	logic [SCR_W-1:0]  px_c, py_c;
	logic              ok_c;
	logic              v_s1;
	logic [NUM_W-1:0]  numx_s1, numy_s1;
	xy_side_t          side_s1;

	assign px_c = SCR_W'(rect_x_q) + SCR_W'(offset_x);
	assign py_c = SCR_W'(rect_y_q) + SCR_W'(offset_y);
	assign ok_c = (offset_x < rect_width_q) && (offset_y < rect_height_q) &&
		(px_c < screen_width_q) && (py_c < screen_height_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s1            <= NUM_W'(offset_x) * NUM_W'(img_width_q);
			numy_s1            <= NUM_W'(offset_y) * NUM_W'(img_height_q);
			side_s1.action     <= action;
			side_s1.ok         <= ok_c;
			side_s1.px         <= px_c;
			side_s1.py         <= py_c;
			side_s1.load_index <= load_index;
			side_s1.load_pixel <= load_pixel;
		end
	end

	// column and row scaling divides
	logic                         xy_valid;
	logic [1:0][SRC_W-1:0]        xy_quo;
	xy_side_t                     xy_side;

	scab_div #(
		.LANES (2),
		.NW    (NUM_W),
		.DW    (RECT_W),
		.QB    (SRC_W),
		.SW    ($bits(xy_side_t))
	) u_div_xy (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.num       ({numy_s1, numx_s1}),
		.den       ({rect_height_q, rect_width_q}),
		.in_side   (side_s1),
		.out_valid (xy_valid),
		.quo       (xy_quo),
		.rem       (),
		.out_side  (xy_side)
	);

	// stage 2: row times image width, row times pitch
	logic                  v_s2;
	logic [2*IMG_W-1:0]    prod_s2;
	logic [SRC_W-1:0]      sx_s2;
	logic [ADDR_W-1:0]     pyw_s2;
	xy_side_t              side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= xy_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= (2*IMG_W)'(xy_quo[1]) * (2*IMG_W)'(img_width_q);
			sx_s2   <= xy_quo[0];
			pyw_s2  <= ADDR_W'(xy_side.py) * ADDR_W'(screen_width_q);
			side_s2 <= xy_side;
		end
	end

	// stage 3: store index wrapped to the store depth, byte address
	logic              v_s3;
	logic [IDX_W-1:0]  idx_s3;
	md_side_t          side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (side_s2.action == ACT_DRAW) begin
				idx_s3 <= prod_s2[IDX_W-1:0] + IDX_W'(sx_s2);
			end else begin
				idx_s3 <= side_s2.load_index;
			end
			side_s3.action <= side_s2.action;
			side_s3.ok     <= side_s2.ok;
			side_s3.addr   <= ADDR_W'((pyw_s2 + ADDR_W'(side_s2.px)) *
				ADDR_W'(BYTES_PER_PIXEL));
			side_s3.pixel  <= side_s2.load_pixel;
		end
	end

	// stage 4: store access; loads write here so order with draws is kept
	logic              v_s4;
	logic              draw_s4;
	logic [ADDR_W-1:0] addr_s4;
	logic [PIX_W-1:0]  rdata;

	scab_ram #(
		.WIDTH (PIX_W),
		.DEPTH (SOURCE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (en && v_s3 && (side_s3.action == ACT_LOAD)),
		.re    (en),
		.addr  (idx_s3),
		.wdata (side_s3.pixel),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			draw_s4 <= (side_s3.action == ACT_DRAW) && side_s3.ok;
			addr_s4 <= side_s3.addr;
		end
	end

	// stage 5: channel times alpha
	logic              v_s5;
	logic              wen_s5;
	logic [ADDR_W-1:0] addr_s5;
	logic [PROD_W-1:0] pr_s5, pg_s5, pb_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wen_s5  <= draw_s4 && (rdata[31:24] != 8'd0);
			addr_s5 <= addr_s4;
			pr_s5   <= PROD_W'(rdata[7:0])   * PROD_W'(rdata[31:24]);
			pg_s5   <= PROD_W'(rdata[15:8])  * PROD_W'(rdata[31:24]);
			pb_s5   <= PROD_W'(rdata[23:16]) * PROD_W'(rdata[31:24]);
		end
	end

	// output register; alpha 255 comes out unchanged through the same divide
	logic                write_enable_q;
	logic [ADDR_W-1:0]   write_address_q;
	logic [COLOR_W-1:0]  write_color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			write_enable_q <= wen_s5;
			if (wen_s5) begin
				write_address_q <= addr_s5;
				write_color_q   <= {div255(pr_s5), div255(pg_s5), div255(pb_s5)};
			end else begin
				write_address_q <= '0;
				write_color_q   <= '0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign write_enable  = write_enable_q;
	assign write_address = write_address_q;
	assign write_color   = write_color_q;

endmodule
